>>> src/dqlc_pkg.sv
// Shared types, codes and constants for the dual quadrature limit counter.
// No dependencies; imported by every module of the block.
`default_nettype none

package dqlc_pkg;

  typedef logic [1:0] phase_t;

  // Signed two-bit step codes
  localparam logic [1:0] STEP_NONE = 2'b00;
  localparam logic [1:0] STEP_UP   = 2'b01;
  localparam logic [1:0] STEP_DN   = 2'b11;

  // Register indexes on the configuration port
  localparam logic CFG_MIN = 1'b0;
  localparam logic CFG_MAX = 1'b1;

  // Reset values of limits and counts, truncated to the count width on use
  localparam int unsigned RESET_MIN   = 1;
  localparam int unsigned RESET_MAX   = 400;
  localparam int unsigned RESET_COUNT = 1;

  localparam phase_t PHASE_RESET = 2'b00;

  typedef struct packed {
    logic [1:0] step;
    logic       moved;
  } dec_t;

  // Next phase in the counting-up order 0 -> 1 -> 3 -> 2 -> 0
  function automatic phase_t up_next(input phase_t p);
    phase_t n;
    case (p)
      2'd0:    n = 2'd1;
      2'd1:    n = 2'd3;
      2'd3:    n = 2'd2;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

>>> src/dqlc_decode.sv
// x4 quadrature phase decoder: old phase and new pin phase to step and moved flag.
// Depends on dqlc_pkg.
`default_nettype none

module dqlc_decode (
  input  wire  dqlc_pkg::phase_t old_phase,
  input  wire  dqlc_pkg::phase_t new_phase,
  output dqlc_pkg::dec_t         dec
);
  import dqlc_pkg::*;

  always_comb begin
    dec.moved = (new_phase != old_phase);
    dec.step  = STEP_NONE;
    if (dec.moved) begin
      if (up_next(old_phase) == new_phase) begin
        dec.step = STEP_UP;
      end else if (up_next(new_phase) == old_phase) begin
        dec.step = STEP_DN;
      end
      // both pins changed: no step
    end
  end

endmodule

`default_nettype wire

>>> src/dqlc_sat.sv
// Count update: applies the step and clamps into [floor, ceiling], ceiling first.
// Depends on dqlc_pkg.
`default_nettype none

module dqlc_sat #(
  parameter int COUNT_BITS = 12
) (
  input  wire [COUNT_BITS-1:0] value,
  input  wire [1:0]            step,
  input  wire [COUNT_BITS-1:0] cnt_min,
  input  wire [COUNT_BITS-1:0] cnt_max,
  output logic [COUNT_BITS-1:0] value_nxt
);
  import dqlc_pkg::*;

  localparam int SW = COUNT_BITS + 2;

  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] lo;
  logic signed [SW-1:0] hi;

  always_comb begin
    sum = $signed({2'b00, value}) + $signed({{COUNT_BITS{step[1]}}, step});
    lo  = $signed({2'b00, cnt_min});
    hi  = $signed({2'b00, cnt_max});
    if (sum > hi) begin
      value_nxt = cnt_max;
    end else if (sum < lo) begin
      value_nxt = cnt_min;
    end else begin
      value_nxt = sum[COUNT_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

>>> src/dual_quadrature_limit_counter.sv
// Dual-bank x4 quadrature decoder with saturating counts, top level.
// Depends on dqlc_pkg, dqlc_decode and dqlc_sat.
//
// Usage:
//   in_*  : one pin sample per word; tdata = {pin_b, pin_a}, tuser = bank select
//           (0 local, 1 remote). Only the selected bank's phase and count move.
//   out_* : one word per sample: both counts after the sample, the step and
//           the moved flag.
//   cfg_* : index 0 writes the floor, index 1 the ceiling; write when idle.
// Timing:
//   A word held in the input register is decoded and applied to the bank
//   state as its result word is registered; one word per cycle sustained
//   while results are taken, set by the combinational decode and clamp.
// Reset:
//   Phases 0, counts 1, floor 1, ceiling 400 (truncated to COUNT_BITS);
//   both channels empty.
// Stall:
//   A held result keeps the bank state frozen; the input register still
//   takes one word, then in_tready drops until the result is taken.
`default_nettype none

module dual_quadrature_limit_counter #(
  parameter int COUNT_BITS = 12
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_tvalid,
  output logic                    in_tready,
  input  wire [7:0]               in_tdata,   // [0] pin_a, [1] pin_b, rest zero
  input  wire                     in_tuser,   // [0] bank_select
  output logic                    out_tvalid,
  input  wire                     out_tready,
  // from bit 0: local_count, remote_count, step_dir, moved, zero fill
  output logic [((2*COUNT_BITS+3+7)/8)*8-1:0] out_tdata,
  input  wire                     cfg_we,
  input  wire                     cfg_index,
  input  wire [COUNT_BITS-1:0]    cfg_wdata
);
  import dqlc_pkg::*;

  localparam int OUT_W = ((2*COUNT_BITS+3+7)/8)*8;
  localparam int PAY_W = 2*COUNT_BITS+3;

  logic                  s1_valid_r;
  phase_t                s1_pins_r;
  logic                  s1_bank_r;
  logic                  adv;

  phase_t                local_phase_r, remote_phase_r;
  logic [COUNT_BITS-1:0] local_r, remote_r, local_nxt, remote_nxt;
  logic [COUNT_BITS-1:0] min_r, max_r;
  logic [1:0]            step_r;
  logic                  moved_r;

  phase_t                old_phase;
  logic [COUNT_BITS-1:0] old_value, new_value;
  dec_t                  dec;

  assign adv       = s1_valid_r && (!out_tvalid || out_tready);
  assign in_tready = !s1_valid_r || adv;

  assign old_phase = s1_bank_r ? remote_phase_r : local_phase_r;
  assign old_value = s1_bank_r ? remote_r : local_r;

  dqlc_decode u_decode (
    .old_phase (old_phase),
    .new_phase (s1_pins_r),
    .dec       (dec)
  );

  dqlc_sat #(.COUNT_BITS(COUNT_BITS)) u_sat (
    .value     (old_value),
    .step      (dec.step),
    .cnt_min   (min_r),
    .cnt_max   (max_r),
    .value_nxt (new_value)
  );

  assign local_nxt  = (adv && !s1_bank_r) ? new_value : local_r;
  assign remote_nxt = (adv &&  s1_bank_r) ? new_value : remote_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_tvalid     <= 1'b0;
      local_phase_r  <= PHASE_RESET;
      remote_phase_r <= PHASE_RESET;
      local_r        <= COUNT_BITS'(RESET_COUNT);
      remote_r       <= COUNT_BITS'(RESET_COUNT);
      min_r          <= COUNT_BITS'(RESET_MIN);
      max_r          <= COUNT_BITS'(RESET_MAX);
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (adv) begin
        out_tvalid <= 1'b1;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
      if (adv && !s1_bank_r) begin
        local_phase_r <= s1_pins_r;
      end
      if (adv && s1_bank_r) begin
        remote_phase_r <= s1_pins_r;
      end
      local_r  <= local_nxt;
      remote_r <= remote_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN: min_r <= cfg_wdata;
          CFG_MAX: max_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_pins_r <= in_tdata[1:0];
      s1_bank_r <= in_tuser;
    end
    if (adv) begin
      step_r  <= dec.step;
      moved_r <= dec.moved;
    end
  end

  assign out_tdata = {{(OUT_W-PAY_W){1'b0}}, moved_r, step_r, remote_r, local_r};

`ifndef NO_ASSERTIONS
  // an inverted window may leave the count on the floor, above the ceiling
  a_local_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !s1_bank_r |=> (local_r <= max_r) || (local_r == min_r))
    else $error("local count above ceiling after update");

  a_remote_held: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_bank_r |=> local_r == $past(local_r))
    else $error("local count changed on remote word");

  a_step_needs_move: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !moved_r |-> step_r == STEP_NONE)
    else $error("step without phase change");
`endif

endmodule

`default_nettype wire

>>> tb/dual_quadrature_limit_counter_tb.sv
// Self-checking testbench for the dual quadrature limit counter.
// Drives pin samples with bursty valid and a stalling receiver, predicts both bank
// counts in its own model and compares every result word. Needs dqlc_pkg and the RTL.
`timescale 1ns / 100ps

module dual_quadrature_limit_counter_tb;
  import dqlc_pkg::*;

  localparam int CW = 12;
  localparam int CNT_TOP = (1 << CW) - 1;

  typedef enum {MV_UP, MV_DN, MV_HOLD, MV_JUMP, MV_ANY} move_t;
  typedef enum {RX_FREE, RX_COIN, RX_PATTERN, RX_SPARSE} rx_mode_t;

  typedef struct {
    logic [CW-1:0] loc_count;
    logic [CW-1:0] rem_count;
    logic [1:0]    step;
    logic          moved;
  } count_word_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [7:0]    in_tdata = '0;
  logic          in_tuser = 1'b0;
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [31:0]   out_tdata;
  logic          cfg_we = 1'b0;
  logic          cfg_index = CFG_MIN;
  logic [CW-1:0] cfg_wdata = '0;

  // predictor state
  int     floor_lim = RESET_MIN;
  int     ceil_lim = RESET_MAX;
  phase_t loc_phase = PHASE_RESET;
  phase_t rem_phase = PHASE_RESET;
  int     loc_value = RESET_COUNT;
  int     rem_value = RESET_COUNT;

  count_word_t expected_q[$];
  int          mismatches = 0;
  int          gap_max = 0;
  int          burst_left = 0;
  int          hold_len = 0;
  rx_mode_t    rx_mode = RX_FREE;

  dual_quadrature_limit_counter #(.COUNT_BITS(CW)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [0] pin_a, [1] pin_b, rest zero
    .in_tuser   (in_tuser),    // [0] bank_select
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [11:0] local, [23:12] remote, [25:24] step, [26] moved
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // counting-up order 0 -> 1 -> 3 -> 2 -> 0
  function automatic phase_t quarter_turn(input phase_t p);
    case (p)
      2'd0:    return 2'd1;
      2'd1:    return 2'd3;
      2'd3:    return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

  function automatic phase_t quarter_back(input phase_t p);
    case (p)
      2'd1:    return 2'd0;
      2'd3:    return 2'd1;
      2'd2:    return 2'd3;
      default: return 2'd2;
    endcase
  endfunction

  function automatic phase_t target_phase(input phase_t p, input move_t m);
    case (m)
      MV_UP:   return quarter_turn(p);
      MV_DN:   return quarter_back(p);
      MV_HOLD: return p;
      MV_JUMP: return ~p;
      default: return phase_t'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic void advance_counts(input logic a, input logic b, input logic bank);
    phase_t      now;
    phase_t      was;
    logic [1:0]  dir;
    int          v;
    count_word_t w;
    now = {b, a};
    was = bank ? rem_phase : loc_phase;
    dir = STEP_NONE;
    if (now != was) begin
      if (quarter_turn(was) == now) dir = STEP_UP;
      else if (quarter_turn(now) == was) dir = STEP_DN;
    end
    v = bank ? rem_value : loc_value;
    if (dir == STEP_UP) v = v + 1;
    else if (dir == STEP_DN) v = v - 1;
    // ceiling test first, so an inverted window lands on the ceiling if above it, else on the floor
    if (v > ceil_lim) v = ceil_lim;
    else if (v < floor_lim) v = floor_lim;
    if (bank) begin
      rem_phase = now;
      rem_value = v;
    end else begin
      loc_phase = now;
      loc_value = v;
    end
    w.loc_count = loc_value[CW-1:0];
    w.rem_count = rem_value[CW-1:0];
    w.step = dir;
    w.moved = (now != was);
    expected_q.push_back(w);
  endfunction

  task automatic send_word(input logic a, input logic b, input logic bank);
    int gap;
    bit taken;
    gap = 0;
    if (gap_max > 0) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, gap_max);
        burst_left = $urandom_range(1, 16);
      end
      burst_left--;
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, b, a};
    in_tuser <= bank;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_tready;
      if (taken) advance_counts(a, b, bank);
      @(posedge clk);
    end
  endtask

  task automatic walk(input logic bank, input move_t m, input int n);
    phase_t p;
    for (int i = 0; i < n; i++) begin
      p = target_phase(bank ? rem_phase : loc_phase, m);
      send_word(p[0], p[1], bank);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_limits(input int lo, input int hi);
    drain_results();
    repeat (3) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MIN;
    cfg_wdata <= lo[CW-1:0];
    @(posedge clk);
    cfg_index <= CFG_MAX;
    cfg_wdata <= hi[CW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    floor_lim = lo;
    ceil_lim = hi;
  endtask

  // each entry {bank, pin_b, pin_a}
  task automatic test_directed_phases();
    logic [2:0] seq [20];
    seq = '{3'b000, 3'b001, 3'b011, 3'b010, 3'b000, 3'b010, 3'b001, 3'b001,
            3'b000, 3'b110, 3'b111, 3'b101, 3'b100, 3'b111, 3'b110, 3'b100,
            3'b100, 3'b011, 3'b101, 3'b001};
    rx_mode = RX_FREE;
    gap_max = 0;
    foreach (seq[i]) send_word(seq[i][0], seq[i][1], seq[i][2]);
  endtask

  task automatic test_limit_extremes();
    rx_mode = RX_COIN;
    gap_max = 3;
    set_limits(0, CNT_TOP);
    walk(1'b0, MV_DN, 6);
    walk(1'b1, MV_UP, 5);
    set_limits(CNT_TOP, 0);
    walk(1'b0, MV_UP, 2);
    walk(1'b1, MV_HOLD, 2);
    set_limits(CNT_TOP, CNT_TOP);
    walk(1'b0, MV_HOLD, 1);
    walk(1'b1, MV_DN, 1);
    set_limits(0, CNT_TOP);
    walk(1'b0, MV_UP, 3);
    walk(1'b1, MV_JUMP, 2);
    set_limits(0, 0);
    walk(1'b0, MV_DN, 2);
    walk(1'b1, MV_ANY, 2);
    set_limits(RESET_MIN, RESET_MAX);
  endtask

  // long receiver hold-off while words keep coming, so the input side backs up
  task automatic test_receiver_hold();
    rx_mode = RX_FREE;
    gap_max = 0;
    hold_len = 300;
    walk(1'b0, MV_UP, 30);
    walk(1'b1, MV_DN, 30);
    drain_results();
  endtask

  task automatic test_random_rounds();
    int     lo;
    int     hi;
    int     k;
    logic   bank;
    logic   upward [2];
    move_t  m;
    phase_t p;
    upward = '{1'b1, 1'b0};
    for (int r = 0; r < 12; r++) begin
      case (r % 6)
        0: begin
          lo = RESET_MIN;
          hi = RESET_MAX;
        end
        1: begin
          lo = $urandom_range(0, CNT_TOP - 15);
          hi = lo + $urandom_range(0, 15);
        end
        2: begin
          lo = 0;
          hi = CNT_TOP;
        end
        3: begin
          hi = $urandom_range(0, CNT_TOP - 95);
          lo = hi + $urandom_range(1, 95);
        end
        4: begin
          lo = $urandom_range(CNT_TOP - 15, CNT_TOP);
          hi = CNT_TOP;
        end
        default: begin
          lo = 0;
          hi = $urandom_range(0, 12);
        end
      endcase
      set_limits(lo, hi);
      if (r == 0) begin
        rx_mode = RX_FREE;
        gap_max = 0;
      end else begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
      end
      for (int i = 0; i < 150; i++) begin
        bank = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0) upward[bank] = ~upward[bank];
        k = $urandom_range(0, 99);
        if (k < 65) m = upward[bank] ? MV_UP : MV_DN;
        else if (k < 78) m = MV_HOLD;
        else if (k < 88) m = MV_JUMP;
        else m = MV_ANY;
        p = target_phase(bank ? rem_phase : loc_phase, m);
        send_word(p[0], p[1], bank);
      end
    end
  endtask

  initial begin : rx_side
    int tick;
    tick = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_len > 0) begin
        out_tready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end else begin
        case (rx_mode)
          RX_FREE:    out_tready <= 1'b1;
          RX_COIN:    out_tready <= ($urandom_range(0, 1) == 1);
          RX_PATTERN: out_tready <= ((tick % 7) > 2);
          default:    out_tready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  always @(negedge clk) begin : check_results
    count_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result word, got %h", $realtime, out_tdata);
      end else begin
        want = expected_q.pop_front();
        if (out_tdata[11:0] !== want.loc_count) begin
          mismatches++;
          $display("%0t: local_count expected %0d got %0d", $realtime, want.loc_count,
                   out_tdata[11:0]);
        end
        if (out_tdata[23:12] !== want.rem_count) begin
          mismatches++;
          $display("%0t: remote_count expected %0d got %0d", $realtime, want.rem_count,
                   out_tdata[23:12]);
        end
        if (out_tdata[25:24] !== want.step) begin
          mismatches++;
          $display("%0t: step_dir expected %b got %b", $realtime, want.step,
                   out_tdata[25:24]);
        end
        if (out_tdata[26] !== want.moved) begin
          mismatches++;
          $display("%0t: moved expected %b got %b", $realtime, want.moved, out_tdata[26]);
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_phases();
    test_limit_extremes();
    test_receiver_hold();
    test_random_rounds();
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> sim.f
src/dqlc_pkg.sv
src/dqlc_decode.sv
src/dqlc_sat.sv
src/dual_quadrature_limit_counter.sv
tb/dual_quadrature_limit_counter_tb.sv
